// ----- design/ttd_pkg.sv -----
// Shared types, register map, format codes and color expansion helpers.
package ttd_pkg;

   localparam int WORD_W     = 16;
   localparam int INDEX_W    = 20;
   localparam int COLOR_W    = 32;
   localparam int FMT_W      = 3;
   localparam int CFG_SIDE_W = 11;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 4;
   localparam int TILE_W     = 4;

   localparam int MAX_SIDE_DEF = 1024;

   // texel formats
   localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGB5A3 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_I4     = 3'd2;
   localparam logic [FMT_W-1:0] FMT_I8     = 3'd3;
   localparam logic [FMT_W-1:0] FMT_IA4    = 3'd4;
   localparam logic [FMT_W-1:0] FMT_IA8    = 3'd5;

   // register byte addresses
   localparam logic [APB_ADDR_W-1:0] ADDR_FORMAT = 4'h0;
   localparam logic [APB_ADDR_W-1:0] ADDR_WIDTH  = 4'h4;
   localparam logic [APB_ADDR_W-1:0] ADDR_HEIGHT = 4'h8;

   localparam logic [FMT_W-1:0]      FORMAT_RST = FMT_RGB565;
   localparam logic [CFG_SIDE_W-1:0] WIDTH_RST  = 11'd8;
   localparam logic [CFG_SIDE_W-1:0] HEIGHT_RST = 11'd8;

   typedef struct packed {
      logic [FMT_W-1:0]      texel_format;
      logic [CFG_SIDE_W-1:0] image_width;
      logic [CFG_SIDE_W-1:0] image_height;
   } ttd_cfg_type;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic               outside_image;
      logic               image_done;
   } ttd_pos_type;

   function automatic logic [TILE_W-1:0] tile_w(input logic [FMT_W-1:0] fmt);
      logic [TILE_W-1:0] r;
      unique case (fmt)
         FMT_I4, FMT_I8, FMT_IA4: r = 4'd8;
         default:                 r = 4'd4;
      endcase
      return r;
   endfunction

   function automatic logic [TILE_W-1:0] tile_h(input logic [FMT_W-1:0] fmt);
      logic [TILE_W-1:0] r;
      unique case (fmt)
         FMT_I4:  r = 4'd8;
         default: r = 4'd4;
      endcase
      return r;
   endfunction

   // n * 17, same as n * 255 / 15
   function automatic logic [7:0] expand4(input logic [3:0] n);
      return {n, n};
   endfunction

   // n * 255 / 31 via reciprocal 8457 / 2^18, exact over all 5-bit n
   function automatic logic [7:0] expand5(input logic [4:0] n);
      logic [12:0] scaled;
      logic [26:0] prod;
      scaled = 13'(n) * 13'd255;
      prod   = 27'(scaled) * 27'd8457;
      return prod[25:18];
   endfunction

   // n * 255 / 7 via reciprocal 9363 / 2^16, exact over all 3-bit n
   function automatic logic [7:0] expand3(input logic [2:0] n);
      logic [10:0] scaled;
      logic [24:0] prod;
      scaled = 11'(n) * 11'd255;
      prod   = 25'(scaled) * 25'd9363;
      return prod[23:16];
   endfunction

endpackage

// ----- design/ttd_channels.sv -----
// Valid/ready channel interfaces for texel words and decoded pixels.
interface ttd_req_if import ttd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] texel_word;

   modport source (output valid, output texel_word, input ready);
   modport sink (input valid, input texel_word, output ready);
endinterface

interface ttd_rsp_if import ttd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] pixel_index;
   logic [COLOR_W-1:0] pixel_color;
   logic               outside_image;
   logic               last_of_item;
   logic               image_done;

   modport source (output valid, output pixel_index, output pixel_color,
                   output outside_image, output last_of_item, output image_done,
                   input ready);
   modport sink (input valid, input pixel_index, input pixel_color,
                 input outside_image, input last_of_item, input image_done,
                 output ready);
endinterface

// ----- design/ttd_csr.sv -----
// APB configuration registers: format, image width, image height.
module ttd_csr import ttd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   output ttd_cfg_type           cfg
);

   ttd_cfg_type cfg_ff, cfg_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr)
            ADDR_FORMAT: cfg_in.texel_format = pwdata[FMT_W-1:0];
            ADDR_WIDTH:  cfg_in.image_width  = pwdata[CFG_SIDE_W-1:0];
            ADDR_HEIGHT: cfg_in.image_height = pwdata[CFG_SIDE_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.texel_format <= FORMAT_RST;
         cfg_ff.image_width  <= WIDTH_RST;
         cfg_ff.image_height <= HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr)
         ADDR_FORMAT: prdata = APB_DATA_W'(cfg_ff.texel_format);
         ADDR_WIDTH:  prdata = APB_DATA_W'(cfg_ff.image_width);
         ADDR_HEIGHT: prdata = APB_DATA_W'(cfg_ff.image_height);
         default:     prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/ttd_color.sv -----
// Texel word to BGRA pixel expansion for all supported formats.
module ttd_color import ttd_pkg::*; (
   input  logic [FMT_W-1:0]   fmt,
   input  logic [WORD_W-1:0]  word,
   input  logic               half,
   output logic [COLOR_W-1:0] color
);

   logic [7:0] b;
   logic [3:0] nib;

   assign b   = word[7:0];
   assign nib = half ? b[3:0] : b[7:4];

   always_comb begin
      unique case (fmt)
         FMT_RGB565: color = {8'hFF, word[15:11], 3'b000, word[10:5], 2'b00,
                              word[4:0], 3'b000};
         FMT_RGB5A3: begin
            if (word[15]) begin
               color = {8'hFF, expand5(word[14:10]), expand5(word[9:5]),
                        expand5(word[4:0])};
            end else begin
               color = {expand3(word[2:0]), expand4(word[14:11]),
                        expand4(word[10:7]), expand4(word[6:3])};
            end
         end
         FMT_I4:  color = {8'hFF, expand4(nib), expand4(nib), expand4(nib)};
         FMT_I8:  color = {8'hFF, b, b, b};
         FMT_IA4: color = {expand4(b[3:0]), expand4(b[7:4]), expand4(b[7:4]),
                           expand4(b[7:4])};
         FMT_IA8: color = {word[7:0], word[15:8], word[15:8], word[15:8]};
         default: color = '0;
      endcase
   end

endmodule

// ----- design/ttd_walker.sv -----
// Tile position counters and bottom-up pixel index computation.
module ttd_walker import ttd_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  ttd_cfg_type cfg,
   input  logic        fire,
   input  logic        half,
   output ttd_pos_type pos
);

   localparam int CW = $clog2(MAX_SIDE) + 1;
   localparam int SW = (CW > CFG_SIDE_W) ? CW : CFG_SIDE_W;
   localparam int PW = 2 * CW;
   localparam int IW = (PW + 1 > INDEX_W) ? PW + 1 : INDEX_W;

   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [2:0]    wx_ff, wx_in, wy_ff, wy_in;

   logic [SW-1:0]     w_raw, h_raw, w_cl, h_cl;
   logic [CW-1:0]     w, h, x, y, rows_below, ncol, nrow;
   logic [TILE_W-1:0] tw, th, wx_eff, nx, ny;
   logic [PW-1:0]     prod;
   logic [IW-1:0]     idx_sum;
   logic              first_i4, second_i4, outside;
   logic              wrap_x, wrap_y, wrap_c, wrap_r;

   // clamp sides to 1..MAX_SIDE
   always_comb begin
      w_raw = SW'(cfg.image_width);
      h_raw = SW'(cfg.image_height);
      if (w_raw == '0) begin
         w_cl = SW'(1);
      end else if (w_raw > SW'(MAX_SIDE)) begin
         w_cl = SW'(MAX_SIDE);
      end else begin
         w_cl = w_raw;
      end
      if (h_raw == '0) begin
         h_cl = SW'(1);
      end else if (h_raw > SW'(MAX_SIDE)) begin
         h_cl = SW'(MAX_SIDE);
      end else begin
         h_cl = h_raw;
      end
   end

   assign w = w_cl[CW-1:0];
   assign h = h_cl[CW-1:0];

   assign tw        = tile_w(cfg.texel_format);
   assign th        = tile_h(cfg.texel_format);
   assign first_i4  = (cfg.texel_format == FMT_I4) && !half;
   assign second_i4 = (cfg.texel_format == FMT_I4) && half;

   // the second I4 pixel sits one column right of the first
   assign wx_eff = {1'b0, wx_ff} + TILE_W'(second_i4);
   assign x      = col_ff + CW'(wx_eff);
   assign y      = row_ff + CW'(wy_ff);

   assign outside    = (x >= w) || (y >= h);
   assign rows_below = h - CW'(1) - y;
   assign prod       = PW'(rows_below) * PW'(w);
   assign idx_sum    = IW'(prod) + IW'(x);

   assign pos.pixel_index   = outside ? '0 : idx_sum[INDEX_W-1:0];
   assign pos.outside_image = outside;
   assign pos.image_done    = wrap_x && wrap_y && wrap_c && wrap_r;

   // advance
   assign nx     = wx_eff + (first_i4 ? TILE_W'(0) : TILE_W'(1));
   assign ny     = {1'b0, wy_ff} + TILE_W'(1);
   assign ncol   = col_ff + CW'(tw);
   assign nrow   = row_ff + CW'(th);
   assign wrap_x = nx >= tw;
   assign wrap_y = ny >= th;
   assign wrap_c = ncol >= w;
   assign wrap_r = nrow >= h;

   always_comb begin
      wx_in  = wx_ff;
      wy_in  = wy_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (fire) begin
         if (!wrap_x) begin
            wx_in = nx[2:0];
         end else begin
            wx_in = '0;
            if (!wrap_y) begin
               wy_in = ny[2:0];
            end else begin
               wy_in = '0;
               if (!wrap_c) begin
                  col_in = ncol;
               end else begin
                  col_in = '0;
                  row_in = wrap_r ? '0 : nrow;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wx_ff  <= '0;
         wy_ff  <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         wx_ff  <= wx_in;
         wy_ff  <= wy_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- design/tiled_texel_decoder.sv -----
// A texel transaction passes the input register, then the result register, before its first pixel shows.
// Throughput: one texel per cycle while the result channel is ready; an I4 texel gives two pixels,
//   since the single decode/position path issues one pixel per cycle.
// Reset: synchronous, active high; clears tile counters, valid flags and
//   restores format RGB565 with an 8x8 image.
module tiled_texel_decoder import ttd_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ttd_req_if.sink               req,
   ttd_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   ttd_cfg_type cfg;
   ttd_pos_type pos;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic              half_ff, half_in;
   logic [WORD_W-1:0] word_ff, word_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] index_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               outside_ff, last_ff, done_ff;

   logic [COLOR_W-1:0] color;
   logic               slot_free, bad_fmt, item_last, fire, retire, accept;

   ttd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ttd_color u_color (
      .fmt   (cfg.texel_format),
      .word  (word_ff),
      .half  (half_ff),
      .color (color)
   );

   ttd_walker #(
      .MAX_SIDE (MAX_SIDE)
   ) u_walker (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (fire),
      .half  (half_ff),
      .pos   (pos)
   );

   // result slot frees up when empty or being drained this cycle
   assign slot_free = !out_valid_ff || rsp.ready;
   // unused format codes: transaction is dropped without a pixel
   assign bad_fmt   = cfg.texel_format > FMT_IA8;
   // I4 holds its word for a second pixel (low nibble)
   assign item_last = !((cfg.texel_format == FMT_I4) && !half_ff);
   assign fire      = in_valid_ff && !bad_fmt && slot_free;
   assign retire    = in_valid_ff && (bad_fmt || (slot_free && item_last));

   assign req.ready = !in_valid_ff || retire;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      word_in     = word_ff;
      half_in     = half_ff;
      if (fire) begin
         half_in = !item_last;
      end else if (retire) begin
         half_in = 1'b0;
      end
      if (retire) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         word_in     = req.texel_word;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         half_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         half_ff      <= half_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (fire) begin
         index_ff   <= pos.pixel_index;
         color_ff   <= color;
         outside_ff <= pos.outside_image;
         last_ff    <= item_last;
         done_ff    <= pos.image_done;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pixel_index   = index_ff;
   assign rsp.pixel_color   = color_ff;
   assign rsp.outside_image = outside_ff;
   assign rsp.last_of_item  = last_ff;
   assign rsp.image_done    = done_ff;

endmodule
